>>> sv/dpp_pkg.sv
// ---------------------------------------------------------------------------
// dpp_pkg
// Shared widths, types and constants for the detrended peak-to-peak block.
// ---------------------------------------------------------------------------
package dpp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HALF_W   = 5;
  localparam int RANGE_W  = 25;
  localparam int FRAC_W   = 8;

  localparam logic [HALF_W-1:0] HALF_RESET = 5'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [HALF_W-1:0]          half_t;
  typedef logic [RANGE_W-1:0]         range_t;

endpackage

>>> sv/detrended_peak_to_peak.sv
// ---------------------------------------------------------------------------
// detrended_peak_to_peak
// Peak-to-peak range of moving-average-detrended samples over one segment.
// ---------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | in_sample, in_last
//   out     | output    | out_valid / out_ready| out_range, out_valid_res
//   cfg     | input     | cfg_valid / cfg_ready| cfg_half_window
//
// Samples are taken one per cycle while in_ready is high; a three-stage pipeline
// forms the residuals. After the last sample the range divide runs one bit per
// cycle, so in_ready stays low after a segment end until the divider is done,
// and longer while a prior result still waits in the output register. cfg_ready
// waits for the residual pipeline to empty and in_ready is held low while
// cfg_valid is high. Reset is synchronous, active low, with half_window at 2.
// The output register lets the next segment stream in while the result waits.
// ---------------------------------------------------------------------------
module detrended_peak_to_peak #(
  parameter int MAX_HALF_WINDOW = 31,
  parameter int MAX_SEGMENT     = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpp_pkg::sample_t in_sample,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output dpp_pkg::range_t  out_range,
  output logic             out_valid_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  dpp_pkg::half_t   cfg_half_window
);
  import dpp_pkg::*;

  localparam int DEPTH_A = 2 * MAX_HALF_WINDOW + 1;
  localparam int DEPTH_B = MAX_HALF_WINDOW;
  localparam int H_W     = $clog2(MAX_HALF_WINDOW + 1);
  localparam int W_W     = H_W + 1;
  localparam int SA_W    = $clog2(DEPTH_A + 1);
  localparam int SB_W    = $clog2(DEPTH_B + 1);
  localparam int CNT_W   = $clog2(MAX_SEGMENT + 1);
  localparam int SUM_W   = SAMPLE_W + 1 + $clog2(DEPTH_A);
  localparam int RES_W   = SUM_W + 1;
  localparam int PROD_W  = SAMPLE_W + W_W + 1;
  localparam int DIFF_W  = RES_W + 1;
  localparam int NUM_W   = DIFF_W + FRAC_W;

  // configuration and window geometry
  half_t            half_r;
  logic [H_W-1:0]   h_eff;
  logic [W_W-1:0]   w_cur;
  logic [SA_W-1:0]  sel_a;
  logic [SB_W-1:0]  sel_b;

  // segment state
  logic                    closing_r, closing_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    old_full;
  logic                    in_acc, cfg_acc;
  sample_t                 tail_a, tail_b;

  // pipeline
  logic                    s1_valid_r, s1_full_r, s1_last_r;
  sample_t                 s1_center_r;
  logic signed [SUM_W-1:0] s1_sum_r;
  logic                    s2_valid_r, s2_full_r, s2_last_r;
  logic signed [RES_W-1:0] s2_res_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [RES_W-1:0] max_r, min_r;
  logic                    any_r, pend_r;

  // divide and result
  logic                    div_start, div_done;
  logic [DIFF_W-1:0]       diff;
  logic [NUM_W-1:0]        quotient;
  logic                    div_any_r;
  logic                    out_valid_r;
  range_t                  out_range_r;
  logic                    out_valid_res_r;

  assign h_eff = (32'(half_r) > MAX_HALF_WINDOW) ? H_W'(MAX_HALF_WINDOW) : H_W'(half_r);
  assign w_cur = {h_eff, 1'b1};
  assign sel_a = SA_W'(DEPTH_A) - SA_W'(w_cur);
  assign sel_b = SB_W'(DEPTH_B) - SB_W'(h_eff);

  // a register write waits until no sample is in the residual pipeline
  assign in_ready  = !closing_r && !cfg_valid;
  assign cfg_ready = !closing_r && !s1_valid_r && !s2_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // tail of chain a is the sample leaving the window, chain b gives the centre
  dpp_chain #(.DEPTH(DEPTH_A), .SEL_W(SA_W)) u_chain_a (
    .clk      (clk),
    .shift_en (in_acc),
    .inj_sel  (sel_a),
    .new_data (in_sample),
    .tail     (tail_a)
  );

  dpp_chain #(.DEPTH(DEPTH_B), .SEL_W(SB_W)) u_chain_b (
    .clk      (clk),
    .shift_en (in_acc),
    .inj_sel  (sel_b),
    .new_data (in_sample),
    .tail     (tail_b)
  );

  assign old_full = 32'(count_r) >= 32'(w_cur);

  always_comb begin
    sum_nxt = sum_r - (old_full ? SUM_W'(tail_a) : SUM_W'(0)) + SUM_W'(in_sample);
    count_nxt = (32'(count_r) < MAX_SEGMENT) ? count_r + 1'b1 : count_r;
  end

  always_comb begin
    closing_nxt = closing_r;
    if (in_acc && in_last) begin
      closing_nxt = 1'b1;
    end else if (div_done) begin
      closing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RESET;
      closing_r <= 1'b0;
      sum_r     <= '0;
      count_r   <= '0;
    end else begin
      closing_r <= closing_nxt;
      if (cfg_acc) begin
        half_r  <= cfg_half_window;
        sum_r   <= '0;
        count_r <= '0;
      end else if (in_acc) begin
        sum_r   <= in_last ? '0 : sum_nxt;
        count_r <= in_last ? '0 : count_nxt;
      end
    end
  end

  // stage 1: window sum and centre sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_center_r <= (h_eff == '0) ? in_sample : tail_b;
      s1_sum_r    <= sum_nxt;
      s1_full_r   <= 32'(count_nxt) >= 32'(w_cur);
      s1_last_r   <= in_last;
    end
  end

  // stage 2: scaled residual
  assign prod = $signed({1'b0, w_cur}) * s1_center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_res_r  <= RES_W'(prod) - RES_W'(s1_sum_r);
      s2_full_r <= s1_full_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: extremes, then hand the range to the divider
  assign div_start = pend_r && !out_valid_r;
  assign diff      = any_r ? DIFF_W'(DIFF_W'(max_r) - DIFF_W'(min_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_acc || div_start) begin
        any_r <= 1'b0;
      end else if (s2_valid_r && s2_full_r) begin
        any_r <= 1'b1;
      end
      if (s2_valid_r && s2_last_r) begin
        pend_r <= 1'b1;
      end else if (div_start) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_full_r) begin
      if (!any_r || s2_res_r > max_r) begin
        max_r <= s2_res_r;
      end
      if (!any_r || s2_res_r < min_r) begin
        min_r <= s2_res_r;
      end
    end
    if (div_start) begin
      div_any_r <= any_r;
    end
  end

  dpp_div #(.NUM_W(NUM_W), .DEN_W(W_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({diff, FRAC_W'(0)}),
    .divisor  (w_cur),
    .done     (div_done),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      out_range_r     <= div_any_r ? RANGE_W'(quotient) : '0;
      out_valid_res_r <= div_any_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_range     = out_range_r;
  assign out_valid_res = out_valid_res_r;

endmodule

>>> sv/dpp_cell.sv
// ---------------------------------------------------------------------------
// dpp_cell
// One sample cell of a delay chain: loads the new sample or its neighbor's.
// ---------------------------------------------------------------------------
module dpp_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             inject,
  input  dpp_pkg::sample_t new_data,
  input  dpp_pkg::sample_t prev_data,
  output dpp_pkg::sample_t data
);
  import dpp_pkg::*;

  sample_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= inject ? new_data : prev_data;
    end
  end

  assign data = data_r;

endmodule

>>> sv/dpp_chain.sv
// ---------------------------------------------------------------------------
// dpp_chain
// Row of sample cells with a selectable entry point and a fixed tail tap.
// A sample entering at cell DEPTH-d reaches the tail d transactions later.
// ---------------------------------------------------------------------------
module dpp_chain #(
  parameter int DEPTH = 63,
  parameter int SEL_W = 6
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [SEL_W-1:0] inj_sel,
  input  dpp_pkg::sample_t new_data,
  output dpp_pkg::sample_t tail
);
  import dpp_pkg::*;

  sample_t cell_q [DEPTH];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    sample_t prev;
    if (j == 0) begin : g_head
      assign prev = new_data;
    end else begin : g_body
      assign prev = cell_q[j-1];
    end
    dpp_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .inject    (inj_sel == SEL_W'(j)),
      .new_data  (new_data),
      .prev_data (prev),
      .data      (cell_q[j])
    );
  end

  assign tail = cell_q[DEPTH-1];

endmodule

>>> sv/dpp_div.sv
// ---------------------------------------------------------------------------
// dpp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dpp_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
